// ===== hdl/nwm_pkg.sv =====
// Shared types, constants and calendar tables for the nth-weekday-of-month block.
// No dependencies; every other file of the block imports this package.
package nwm_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int WDAY_W     = 3;
  localparam int SEL_W      = 5;
  localparam int DAY_W      = 5;
  localparam int OCC_W      = 3;
  localparam int SUM_W      = 15;

  localparam logic [YEAR_W-1:0] MAX_YEAR        = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR      = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
  localparam logic [WDAY_W-1:0]  DAYS_PER_WEEK  = 3'd7;
  localparam logic [DAY_W-1:0]   MIN_MONTH_DAYS = 5'd28;
  localparam logic [OCC_W-1:0]   MAX_OCCURRENCES = 3'd5;
  localparam logic [OCC_W-1:0]   MIN_OCCURRENCES = 3'd4;

  // Reciprocal of 100 scaled by 2^19; exact floor for all 14-bit operands.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // Per-stage load enables handed from the top level to the datapath modules.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } nwm_ld_t;

  // Month offset for the weekday formula of the 1st.
  function automatic logic [2:0] month_shift(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Month length in a common year.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:                   r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/nwm_req_if.sv =====
// Request channel of the nth-weekday-of-month block: valid/ready plus query fields.
// Depends on nwm_pkg for the field widths.
interface nwm_req_if import nwm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [YEAR_W-1:0]        year;
  logic [MONTH_W-1:0]       month;
  logic [WDAY_W-1:0]        weekday;
  logic signed [SEL_W-1:0]  selector;

  modport source (output valid, year, month, weekday, selector, input ready);
  modport sink   (input valid, year, month, weekday, selector, output ready);
endinterface

// ===== hdl/nwm_res_if.sv =====
// Result channel of the nth-weekday-of-month block: valid/ready plus answer fields.
// Depends on nwm_pkg for the field widths.
interface nwm_res_if import nwm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [DAY_W-1:0]   day_of_month;
  logic [OCC_W-1:0]   occurrences;

  modport source (output valid, found, day_of_month, occurrences, input ready);
  modport sink   (input valid, found, day_of_month, occurrences, output ready);
endinterface

// ===== hdl/nth_weekday_of_month.sv =====
// Top level of the nth-weekday-of-month block: pipeline control and the two datapaths.
// Depends on nwm_pkg, nwm_req_if, nwm_res_if, nwm_cal and nwm_occ.
//
// Usage: a query (year, month, weekday 1..7 = Monday..Sunday, signed selector)
// is offered on the req channel; the answer (found, day_of_month, occurrences)
// leaves on the res channel. A transaction completes at a rising clock edge
// where valid and ready are both high on that channel.
// The block is a four-stage pipeline: century quotients, then leap year and
// the weekday sum, then the weekday of the 1st and the first-match offset,
// then the count and the selected day into the output register. The request
// transaction loads the first stage; its valid bit then moves through the
// second, third and fourth stage, whose valid bit is res.valid. One query
// is taken every cycle, limited only by the receiver.
// Each stage holds a valid bit and advances when it is empty or the stage
// after it advances, so a stalled receiver fills the pipeline from the back,
// and req.ready stays high while any stage still has room. Nothing is lost or
// repeated under a stall. A synchronous reset clears the valid bits; the
// payload registers are left as they are. Out-of-range weekday, year or month
// give an all-zero answer; a zero or unreachable selector gives found low
// with the count still reported.
module nth_weekday_of_month import nwm_pkg::*; (
  input  logic clk,
  input  logic rst,
  nwm_req_if.sink   req,
  nwm_res_if.source res
);

  logic [3:0] vld;
  nwm_ld_t    ld;

  // Load chain from the back: a stage moves when empty or when its successor moves.
  always_comb begin
    ld.ld4 = !vld[3] || res.ready;
    ld.ld3 = !vld[2] || ld.ld4;
    ld.ld2 = !vld[1] || ld.ld3;
    ld.ld1 = !vld[0] || ld.ld2;
  end

  assign req.ready = ld.ld1;
  assign res.valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld.ld1) vld[0] <= req.valid;
      if (ld.ld2) vld[1] <= vld[0];
      if (ld.ld3) vld[2] <= vld[1];
      if (ld.ld4) vld[3] <= vld[2];
    end
  end

  logic [SUM_W-1:0]        sum2;
  logic [DAY_W-1:0]        len2;
  logic [WDAY_W-1:0]       wday2;
  logic signed [SEL_W-1:0] sel2;
  logic                    ok2;

  nwm_cal u_cal (
    .clk      (clk),
    .ld       (ld),
    .year     (req.year),
    .month    (req.month),
    .weekday  (req.weekday),
    .selector (req.selector),
    .sum      (sum2),
    .len      (len2),
    .wday     (wday2),
    .sel      (sel2),
    .ok       (ok2)
  );

  nwm_occ u_occ (
    .clk          (clk),
    .ld           (ld),
    .sum          (sum2),
    .len          (len2),
    .wday         (wday2),
    .sel          (sel2),
    .ok           (ok2),
    .found        (res.found),
    .day_of_month (res.day_of_month),
    .occurrences  (res.occurrences)
  );

endmodule

// ===== hdl/nwm_cal.sv =====
// Calendar stages 1 and 2: century quotients, leap year, month length, day-count sum.
// Depends on nwm_pkg.
module nwm_cal import nwm_pkg::*; (
  input  logic                    clk,
  input  nwm_ld_t                 ld,
  input  logic [YEAR_W-1:0]       year,
  input  logic [MONTH_W-1:0]      month,
  input  logic [WDAY_W-1:0]       weekday,
  input  logic signed [SEL_W-1:0] selector,
  output logic [SUM_W-1:0]        sum,
  output logic [DAY_W-1:0]        len,
  output logic [WDAY_W-1:0]       wday,
  output logic signed [SEL_W-1:0] sel,
  output logic                    ok
);

  // Stage 1 registers.
  logic [YEAR_W-1:0]       year1;
  logic [YEAR_W-1:0]       yy1;
  logic [7:0]              qyy1;
  logic [7:0]              qy1;
  logic [MONTH_W-1:0]      month1;
  logic [WDAY_W-1:0]       wday1;
  logic signed [SEL_W-1:0] sel1;
  logic                    ok1;

  logic [YEAR_W-1:0]       yy_next;
  logic [YEAR_W+12:0]      pyy;
  logic [YEAR_W+12:0]      py;
  logic                    ok_next;

  always_comb begin
    yy_next = (month < MONTH_MAR) ? year - 14'd1 : year;
    pyy     = {13'd0, yy_next} * {14'd0, RECIP_100};
    py      = {13'd0, year} * {14'd0, RECIP_100};
    ok_next = (weekday != '0) && (year != '0) && (year <= MAX_YEAR) &&
              (month >= MONTH_JAN) && (month <= MONTH_DEC);
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      year1  <= year;
      yy1    <= yy_next;
      qyy1   <= pyy[RECIP_SHIFT+7:RECIP_SHIFT];
      qy1    <= py[RECIP_SHIFT+7:RECIP_SHIFT];
      month1 <= month;
      wday1  <= weekday;
      sel1   <= selector;
      ok1    <= ok_next;
    end
  end

  // Stage 2: leap test and the weekday sum (reduced mod 7 in the next stage).
  logic [SUM_W-1:0] sum_next;
  logic [DAY_W-1:0] len_next;
  logic             cent;
  logic             leap;

  always_comb begin
    cent = ({1'b0, year1} == ({7'd0, qy1} * 15'd100));
    leap = ((year1[1:0] == 2'b00) && !cent) || (cent && (qy1[1:0] == 2'b00));
    len_next = month_days(month1);
    if ((month1 == MONTH_FEB) && leap) begin
      len_next = MIN_MONTH_DAYS + 5'd1;
    end
    sum_next = {1'b0, yy1} + {3'd0, yy1[YEAR_W-1:2]} - {7'd0, qyy1} +
               {9'd0, qyy1[7:2]} + {12'd0, month_shift(month1)} + 15'd1;
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      sum  <= sum_next;
      len  <= len_next;
      wday <= wday1;
      sel  <= sel1;
      ok   <= ok1;
    end
  end

endmodule

// ===== hdl/nwm_occ.sv =====
// Occurrence stages 3 and 4: weekday of the 1st, first-match offset, count, answer.
// Depends on nwm_pkg.
module nwm_occ import nwm_pkg::*; (
  input  logic                    clk,
  input  nwm_ld_t                 ld,
  input  logic [SUM_W-1:0]        sum,
  input  logic [DAY_W-1:0]        len,
  input  logic [WDAY_W-1:0]       wday,
  input  logic signed [SEL_W-1:0] sel,
  input  logic                    ok,
  output logic                    found,
  output logic [DAY_W-1:0]        day_of_month,
  output logic [OCC_W-1:0]        occurrences
);

  // Stage 3: sum mod 7 by folding octal digits (8 is 1 mod 7).
  logic [5:0]        fold;
  logic [3:0]        fold2;
  logic [2:0]        dmod;
  logic [2:0]        first;
  logic [3:0]        wsum;
  logic [2:0]        offset_next;

  always_comb begin
    fold  = {3'd0, sum[2:0]} + {3'd0, sum[5:3]} + {3'd0, sum[8:6]} +
            {3'd0, sum[11:9]} + {3'd0, sum[14:12]};
    fold2 = {1'b0, fold[2:0]} + {1'b0, fold[5:3]};
    dmod  = (fold2 >= {1'b0, DAYS_PER_WEEK}) ? 3'(fold2 - {1'b0, DAYS_PER_WEEK})
                                             : fold2[2:0];
    first = (dmod == 3'd0) ? DAYS_PER_WEEK : dmod;
    wsum  = {1'b0, wday} + {1'b0, DAYS_PER_WEEK} - {1'b0, first};
    offset_next = (wsum >= {1'b0, DAYS_PER_WEEK}) ? 3'(wsum - {1'b0, DAYS_PER_WEEK})
                                                  : wsum[2:0];
  end

  logic [2:0]              offset3;
  logic [DAY_W-1:0]        len3;
  logic signed [SEL_W-1:0] sel3;
  logic                    ok3;

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      offset3 <= offset_next;
      len3    <= len;
      sel3    <= sel;
      ok3     <= ok;
    end
  end

  // Stage 4: count, selector resolution and day of month.
  logic [DAY_W-1:0]  rem;
  logic [OCC_W-1:0]  cnt;
  logic signed [5:0] sadj;
  logic              hit;
  logic [2:0]        idx;
  logic [5:0]        day6;

  always_comb begin
    rem  = len3 - 5'd1 - {2'd0, offset3};
    cnt  = (rem >= MIN_MONTH_DAYS) ? MAX_OCCURRENCES : MIN_OCCURRENCES;
    sadj = $signed({sel3[SEL_W-1], sel3});
    if (sel3 < 0) begin
      sadj = sadj + $signed({3'd0, cnt}) + 6'sd1;
    end
    hit  = ok3 && (sadj >= 6'sd1) && (sadj <= $signed({3'd0, cnt}));
    idx  = sadj[2:0] - 3'd1;
    day6 = 6'd1 + {3'd0, offset3} + ({idx, 3'd0} - {3'd0, idx});
  end

  always_ff @(posedge clk) begin
    if (ld.ld4) begin
      found        <= hit;
      day_of_month <= hit ? day6[DAY_W-1:0] : '0;
      occurrences  <= ok3 ? cnt : '0;
    end
  end

endmodule

// ===== hdl/nwm_checker.sv =====
// Port-level checks for the nth-weekday-of-month block, bound to its top level.
// Depends on nwm_pkg and on the top level nth_weekday_of_month.
module nwm_checker import nwm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic             found,
  input logic [DAY_W-1:0] day_of_month,
  input logic [OCC_W-1:0] occurrences
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(found) &&
      $stable(day_of_month) && $stable(occurrences))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> occurrences == 3'd0 || occurrences == MIN_OCCURRENCES ||
      occurrences == MAX_OCCURRENCES)
    else $error("occurrence count out of range");

  a_found_day: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (found && day_of_month != '0 && occurrences != '0) ||
      (!found && day_of_month == '0))
    else $error("found flag inconsistent with day or count");

  a_day_reach: assert property (@(posedge clk) disable iff (rst)
    res_valid && found |->
      ({3'd0, day_of_month} <= {5'd0, occurrences} * 8'd7))
    else $error("day lies beyond the last occurrence");

endmodule

bind nth_weekday_of_month nwm_checker u_nwm_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .found        (res.found),
  .day_of_month (res.day_of_month),
  .occurrences  (res.occurrences)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nth_weekday_of_month: directed corner queries, then random traffic.
// Depends on nwm_pkg, nwm_req_if, nwm_res_if and the block under test; it needs no other file.

module testbench;
  import nwm_pkg::*;

  // The run ends with a failure if it goes on longer than this. The slowest
  // correct run, with both sides stalling, stays far below it.
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RESET_CYCLES  = 10;
  // Four pipeline stages up to res.valid, plus some margin.
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 370;

  localparam logic [WDAY_W-1:0] WDAY_NONE = '0;
  localparam logic [WDAY_W-1:0] WDAY_MON  = 3'd1;
  localparam logic [WDAY_W-1:0] WDAY_TUE  = 3'd2;
  localparam logic [WDAY_W-1:0] WDAY_WED  = 3'd3;
  localparam logic [WDAY_W-1:0] WDAY_SUN  = 3'd7;

  // One expected answer, at the widths of the result channel.
  typedef struct packed {
    logic             found;
    logic [DAY_W-1:0] day;
    logic [OCC_W-1:0] occ;
  } answer_t;

  // Holds the answers still owed by the block, oldest first, and computes
  // each one from the query when the query transaction completes.
  class weekday_scoreboard;
    answer_t pending_answers[$];
    int      mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Day-of-week anchor per month for the 1st (index 1 = January).
    function int month_anchor(int m);
      int anchors[13];
      anchors = '{0, 0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
      return anchors[m];
    endfunction

    function int month_length(int y, int m);
      int lengths[13];
      lengths = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
        return 29;
      return lengths[m];
    endfunction

    function answer_t predict_answer(logic [YEAR_W-1:0] year, logic [MONTH_W-1:0] month,
                                     logic [WDAY_W-1:0] wday,
                                     logic signed [SEL_W-1:0] sel);
      answer_t a;
      int      y;
      int      m;
      int      w;
      int      yy;
      int      len;
      int      first;
      int      offset;
      int      cnt;
      int      pos;
      a = '0;
      y = year;
      m = month;
      w = wday;
      pos = sel;
      if (w >= 1 && w <= 7 && y >= 1 && y <= MAX_YEAR && m >= 1 && m <= 12) begin
        len = month_length(y, m);
        // January and February count against the previous year.
        yy = (m < 3) ? y - 1 : y;
        first = (yy + yy / 4 - yy / 100 + yy / 400 + month_anchor(m) + 1) % 7;
        if (first == 0)
          first = 7;
        offset = (w + 7 - first) % 7;
        cnt = 1 + (len - 1 - offset) / 7;
        if (cnt > MAX_OCCURRENCES)
          cnt = MAX_OCCURRENCES;
        if (pos < 0)
          pos = pos + cnt + 1;
        a.occ = cnt[OCC_W-1:0];
        if (pos >= 1 && pos <= cnt) begin
          a.found = 1'b1;
          a.day   = 5'(1 + offset + 7 * (pos - 1));
        end
      end
      return a;
    endfunction

    function void note_query(logic [YEAR_W-1:0] year, logic [MONTH_W-1:0] month,
                             logic [WDAY_W-1:0] wday, logic signed [SEL_W-1:0] sel);
      pending_answers.push_back(predict_answer(year, month, wday, sel));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_answer(logic found, logic [DAY_W-1:0] day, logic [OCC_W-1:0] occ);
      answer_t want;
      if (pending_answers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected answer found=%0d day=%0d occurrences=%0d",
                 $time, found, day, occ);
        return;
      end
      want = pending_answers.pop_front();
      compare_field("found", 8'(want.found), 8'(found));
      compare_field("day_of_month", 8'(want.day), 8'(day));
      compare_field("occurrences", 8'(want.occ), 8'(occ));
    endfunction

    function int outstanding();
      return pending_answers.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  // Chance in percent that the sender or the receiver holds off in a cycle.
  int   send_idle_pct;
  int   recv_idle_pct;

  weekday_scoreboard calendar_board;

  nwm_req_if req_ch ();
  nwm_res_if res_ch ();

  nth_weekday_of_month dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Watchdog: a hung handshake or a lost answer ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side. An answer transaction completes at an edge where valid and
  // ready are both high; the values read here are those from before the edge.
  // Ready is then redrawn for the next cycle, once per edge, so that stalls
  // land on every stage of a fill or a drain of the pipeline.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        calendar_board.check_answer(res_ch.found, res_ch.day_of_month, res_ch.occurrences);
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one query and returns at the edge where its transaction completes.
  // The task is entered at a rising edge. A gap is drawn first; without one,
  // valid stays high from the previous query so that back-to-back
  // transactions are possible and valid is never lowered and raised in the
  // same time step.
  task automatic send_query(logic [YEAR_W-1:0] year, logic [MONTH_W-1:0] month,
                            logic [WDAY_W-1:0] wday, logic signed [SEL_W-1:0] sel);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct)
        @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.year     <= year;
    req_ch.month    <= month;
    req_ch.weekday  <= wday;
    req_ch.selector <= sel;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    calendar_board.note_query(year, month, wday, sel);
  endtask

  // The sender goes quiet until every answer owed has come back.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    while (calendar_board.outstanding() != 0)
      @(posedge clk);
  endtask

  // Corner queries: the ends of every field, invalid dates and weekdays, a
  // zero selector, selectors past the count in both directions, leap and
  // non-leap Februaries, and months whose weekdays wrap past Sunday.
  task automatic run_directed();
    int w;
    send_query(14'd1, MONTH_JAN, WDAY_MON, 5'sd1);            // earliest date
    send_query(MAX_YEAR, MONTH_DEC, WDAY_SUN, -5'sd1);        // latest month, last one
    send_query(14'd0, 4'd5, WDAY_WED, 5'sd1);                 // year zero
    send_query(14'd10000, 4'd5, WDAY_WED, 5'sd1);             // year just past range
    send_query(14'h3FFF, 4'hF, WDAY_SUN, -5'sd16);            // year, month, weekday at top; selector at its lowest
    send_query(14'd2024, 4'd0, WDAY_TUE, 5'sd1);              // month zero
    send_query(14'd2024, 4'd13, WDAY_TUE, 5'sd1);             // month just past range
    send_query(14'd2024, 4'd6, WDAY_NONE, 5'sd1);             // weekday zero
    for (w = 1; w <= DAYS_PER_WEEK; w++)
      send_query(14'd2024, MONTH_MAR, 3'(w), (w % 2 == 1) ? 5'sd5 : -5'sd5);
    send_query(14'd2023, 4'd7, WDAY_WED, 5'sd0);              // zero selector
    send_query(14'd2023, 4'd7, WDAY_WED, 5'sd15);             // largest positive selector
    send_query(14'd2023, 4'd7, WDAY_WED, -5'sd16);            // most negative selector
    send_query(14'd2023, 4'd7, WDAY_MON, 5'sd6);
    send_query(14'd2023, 4'd7, WDAY_MON, -5'sd6);
    send_query(14'd2000, MONTH_FEB, WDAY_TUE, -5'sd1);        // leap by the 400 rule
    send_query(14'd1900, MONTH_FEB, WDAY_WED, -5'sd1);        // century, not leap
    send_query(14'd2021, MONTH_FEB, WDAY_MON, 5'sd4);         // exactly four weeks
    send_query(14'd2021, 4'd8, WDAY_TUE, 5'sd5);              // starts on Sunday, wraps
  endtask

  // Mostly well-formed queries with random content; about one in ten is
  // raw noise over the full width of every field.
  task automatic run_random(int count);
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic [WDAY_W-1:0]       wday;
    logic signed [SEL_W-1:0] sel;
    int                      pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        year  = YEAR_W'($urandom_range(16383));
        month = MONTH_W'($urandom_range(15));
        wday  = WDAY_W'($urandom_range(7));
        sel   = SEL_W'($urandom_range(31));
      end else begin
        if (pick < 14)
          year = YEAR_W'((pick[0]) ? $urandom_range(1, 8) : $urandom_range(9990, 9999));
        else
          year = YEAR_W'($urandom_range(1, MAX_YEAR));
        month = MONTH_W'($urandom_range(1, 12));
        wday  = WDAY_W'($urandom_range(1, 7));
        sel   = 5'(int'($urandom_range(10)) - 5);
      end
      send_query(year, month, wday, sel);
    end
  endtask

  initial begin
    int phase;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.year     = '0;
    req_ch.month    = '0;
    req_ch.weekday  = '0;
    req_ch.selector = '0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    calendar_board  = new();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    hold_until_drained();

    // Three phases of random traffic: a slow sender with a slower receiver,
    // then the roles swapped, then both sides at full rate. Between phases
    // the sender waits for the pipeline to empty completely.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_random(PHASE_ITEMS);
      hold_until_drained();
    end

    // Let any stray answer surface before judging the run.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (calendar_board.mismatches == 0 && calendar_board.outstanding() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/nwm_pkg.sv
hdl/nwm_req_if.sv
hdl/nwm_res_if.sv
hdl/nwm_cal.sv
hdl/nwm_occ.sv
hdl/nth_weekday_of_month.sv
hdl/nwm_checker.sv
sim/testbench.sv
